FILE: sv/double_ended_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared property templates, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed (same cycle)");

// cons must hold in the cycle after ante
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed (next cycle)");

`endif

FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Sizes, request codes and the per-cycle control bundle sent to every cell.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  // the chain's move for one request; at most one bit set
  typedef struct packed {
    logic shift_right;  // push front: every entry moves one cell back
    logic shift_left;   // pop front: every entry moves one cell forward
    logic push_back;    // first empty cell takes the value
    logic pop_back;     // last occupied cell drops its entry
  } deq_ctl_t;

endpackage

FILE: sv/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the chain: holds an entry and a valid bit, trades with neighbors.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  deq_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_valid,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] data,
  output logic                     valid,
  output logic                     is_back
);

  logic take_push;
  logic take_pop;

  // occupied cells form a run from cell 0, so the tail is valid with an empty right
  assign is_back   = valid && !right_valid;
  assign take_push = ctl.push_back && !valid && left_valid;
  assign take_pop  = ctl.pop_back && is_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift_right) begin
      valid <= left_valid;
    end else if (ctl.shift_left) begin
      valid <= right_valid;
    end else if (take_push) begin
      valid <= 1'b1;
    end else if (take_pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_right) begin
      data <= left_data;
    end else if (ctl.shift_left) begin
      data <= right_data;
    end else if (take_push) begin
      data <= value;
    end
  end

endmodule

FILE: sv/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue, top level
// Bounded deque of signed 32-bit entries kept in a shifting chain of cells.
// ----------------------------------------------------------------------------
// A request (mode, value) is taken on any clock edge with start high; busy
// never rises, so one request per cycle is sustained. Each request gives
// exactly one result, flagged by done in the following cycle only; the
// receiver cannot stall, so it must capture front_value, back_value,
// occupancy, empty_error and full_error in that cycle. The result is
// registered in the cell chain: every cell moves its entry at the same
// edge, so front is always cell 0 and back is the last occupied cell.
// A pop on an empty queue sets empty_error, a push on a full queue sets
// full_error; either leaves the contents untouched. An empty queue reports
// zero for both front_value and back_value. No clearing pass after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     empty_error,
  output logic                     full_error
);

`include "double_ended_queue_top_macros.svh"

  // chain taps
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_back;

  deq_ctl_t   ctl;
  mode_t      req_mode;
  logic       q_empty;
  logic       q_full;
  logic       is_push;
  logic       refused_pop;
  logic       refused_push;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic signed [DATA_W-1:0] back_acc;

  // every cell updates at the request's own edge, so requests never wait
  assign busy = 1'b0;

  assign req_mode = mode_t'(mode);
  assign q_empty  = !cell_valid[0];
  assign q_full   = cell_valid[DEPTH-1];
  assign is_push  = req_mode inside {MODE_PUSH_FRONT, MODE_PUSH_BACK};

  assign refused_push = start && is_push && q_full;
  assign refused_pop  = start && !is_push && q_empty;

  always_comb begin
    ctl = '0;
    if (start) begin
      case (req_mode)
        MODE_PUSH_FRONT: ctl.shift_right = !q_full;
        MODE_PUSH_BACK:  ctl.push_back   = !q_full;
        MODE_POP_FRONT:  ctl.shift_left  = !q_empty;
        MODE_POP_BACK:   ctl.pop_back    = !q_empty;
        default:         ctl = '0;
      endcase
    end
  end

  // occupancy tracks the valid run in the chain
  always_comb begin
    count_next = count;
    if (ctl.shift_right || ctl.push_back) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.shift_left || ctl.pop_back) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      done        <= 1'b0;
      empty_error <= 1'b0;
      full_error  <= 1'b0;
    end else begin
      count       <= count_next;
      done        <= start;
      empty_error <= refused_pop;
      full_error  <= refused_push;
    end
  end

  // cell 0 takes a front push from the request; the tail sees nothing beyond it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_valid;
    logic signed [DATA_W-1:0] right_data;
    logic                     right_valid;

    if (i == 0) begin : g_head
      assign left_data  = value;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .value       (value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .is_back     (cell_back[i])
    );
  end

  // at most one cell flags itself as back, so an AND-OR select is enough
  always_comb begin
    back_acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_acc = back_acc | (cell_data[i] & {DATA_W{cell_back[i]}});
    end
  end

  // empty queue reads as zero: no valid cell contributes
  assign front_value = cell_valid[0] ? cell_data[0] : '0;
  assign back_value  = back_acc;
  assign occupancy   = OCC_W'(count);

  // ---- checks ----
  `DEQ_ASSERT_NOW(a_count_matches_chain, 1'b1, $countones(cell_valid) == 32'(count))
  `DEQ_ASSERT_NOW(a_single_back, 1'b1, $onehot0(cell_back))
  `DEQ_ASSERT_NEXT(a_result_follows_request, start, done)
  `DEQ_ASSERT_NOW(a_full_flag_at_capacity, done && full_error, count == CNT_W'(DEPTH))

endmodule

FILE: verif/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the double-ended queue
// Drives push/pop requests through the command handshake and checks every
// result against a ring-buffer prediction kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int TOTAL_RANDOM = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 4;
  localparam int MAX_REPORTS  = 10;

  // One entry of the stimulus list. A drain_first entry carries no request:
  // the driver holds off until every outstanding result has been checked.
  typedef struct {
    mode_t                    op;
    logic signed [DATA_W-1:0] data;
    int unsigned              idle_pct;
    bit                       drain_first;
  } deq_request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     empty_error;
    logic                     full_error;
  } deq_view_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               mode = MODE_PUSH_FRONT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     done;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [OCC_W-1:0]         occupancy;
  logic                     empty_error;
  logic                     full_error;

  deq_request_t pending_reqs[$];
  deq_view_t    expected_views[$];

  // testbench copy of the queue contents: ring, head position and fill count
  logic signed [DATA_W-1:0] ring_model[DEPTH];
  int unsigned              head_pos = 0;
  int unsigned              fill_count = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  double_ended_queue_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .value       (value),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .occupancy   (occupancy),
    .empty_error (empty_error),
    .full_error  (full_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the ring and returns the view the block must show.
  // Refused requests (pop when empty, push when full) leave the ring alone.
  function automatic deq_view_t apply_request(mode_t op, logic signed [DATA_W-1:0] data);
    deq_view_t v;
    v = '0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          v.full_error = 1'b1;
        end else if (op == MODE_PUSH_FRONT) begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring_model[head_pos] = data;
          fill_count++;
        end else begin
          ring_model[(head_pos + fill_count) % DEPTH] = data;
          fill_count++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (fill_count == 0) begin
          v.empty_error = 1'b1;
        end else if (op == MODE_POP_FRONT) begin
          head_pos = (head_pos + 1) % DEPTH;
          fill_count--;
        end else begin
          fill_count--;
        end
      end
      default: begin
      end
    endcase
    // only occupied slots are read; an empty queue shows zero on both ends
    if (fill_count != 0) begin
      v.front_value = ring_model[head_pos];
      v.back_value  = ring_model[(head_pos + fill_count - 1) % DEPTH];
    end
    v.occupancy = fill_count[OCC_W-1:0];
    return v;
  endfunction

  function automatic void add_request(mode_t op, logic signed [DATA_W-1:0] data,
                                      int unsigned idle_pct);
    deq_request_t r;
    r.op          = op;
    r.data        = data;
    r.idle_pct    = idle_pct;
    r.drain_first = 1'b0;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_drain_pause();
    deq_request_t r;
    r.op          = MODE_PUSH_FRONT;
    r.data        = '0;
    r.idle_pct    = 0;
    r.drain_first = 1'b1;
    pending_reqs.push_back(r);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Driver: a request stays on the pins until an edge sees start && !busy.
  // At most one nonblocking write of start per edge.
  always @(posedge clk) begin : drive_requests
    deq_request_t nxt;
    bit           present;
    present = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // a pause entry clears only after an edge with no request in flight and
      // nothing left to check
      if (pending_reqs.size() > 0 && pending_reqs[0].drain_first) begin
        if (!start && expected_views.size() == 0) void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && !pending_reqs[0].drain_first &&
          $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        nxt     = pending_reqs.pop_front();
        mode    <= nxt.op;
        value   <= nxt.data;
        present = 1'b1;
      end
      start <= present;
    end
  end

  // Monitor: check the result of the earlier request before predicting the
  // one accepted on this edge, so a back-to-back stream stays in order.
  always @(posedge clk) begin : watch_results
    deq_view_t want;
    if (!rst) begin
      if (done) begin
        if (expected_views.size() == 0) begin
          note_mismatch($sformatf("unexpected result: front=%0d back=%0d occ=%0d",
                                  front_value, back_value, occupancy));
        end else begin
          want = expected_views.pop_front();
          if (front_value !== want.front_value || back_value !== want.back_value ||
              occupancy !== want.occupancy || empty_error !== want.empty_error ||
              full_error !== want.full_error) begin
            note_mismatch($sformatf(
              "mismatch: front %0d/%0d back %0d/%0d occ %0d/%0d empty %b/%b full %b/%b (exp/act)",
              want.front_value, front_value, want.back_value, back_value,
              want.occupancy, occupancy, want.empty_error, empty_error,
              want.full_error, full_error));
          end
        end
      end
      if (start && !busy) expected_views.push_back(apply_request(mode_t'(mode), value));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : run_test
    int unsigned issued;
    int unsigned burst_len;
    int unsigned push_pct;
    int unsigned idle_pct;
    int unsigned op_pick;
    mode_t       op;

    // Directed part: pops on the empty queue, first push at either end,
    // extreme values, a fill to full with refused pushes at both ends.
    add_request(MODE_POP_FRONT, 32'sd0, 34);
    add_request(MODE_POP_BACK, -32'sd1, 34);
    add_request(MODE_PUSH_FRONT, 32'sh8000_0000, 34);  // first push, front side
    add_request(MODE_POP_BACK, 32'sd0, 34);             // back to empty
    add_request(MODE_PUSH_BACK, 32'sh7fff_ffff, 34);   // first push, back side
    add_request(MODE_PUSH_FRONT, -32'sd1, 34);
    add_request(MODE_POP_FRONT, 32'sd5, 34);
    for (int i = 0; i < DEPTH - 1; i++) begin
      add_request(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                  (i == 3) ? 32'sd0 : $signed($urandom()), 34);
    end
    add_request(MODE_PUSH_FRONT, 32'sh7fff_ffff, 34);  // full, refused
    add_request(MODE_PUSH_BACK, 32'sh8000_0000, 34);   // full, refused
    add_drain_pause();

    // Random part in bursts: push-heavy bursts fill the ring to full,
    // pop-heavy bursts drain it past empty, balanced ones wander in between.
    // Sender idling: 34% in the first third, 70% in the second, none after.
    issued = 0;
    while (issued < TOTAL_RANDOM) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(100);
      endcase
      for (int k = 0; k < burst_len && issued < TOTAL_RANDOM; k++) begin
        if (issued == TOTAL_RANDOM / 3 || issued == 2 * TOTAL_RANDOM / 3) add_drain_pause();
        if (issued < TOTAL_RANDOM / 3) idle_pct = 34;
        else if (issued < 2 * TOTAL_RANDOM / 3) idle_pct = 70;
        else idle_pct = 0;
        op_pick = $urandom_range(1);
        if ($urandom_range(99) < push_pct) op = op_pick ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else op = op_pick ? MODE_POP_BACK : MODE_POP_FRONT;
        add_request(op, $signed($urandom()), idle_pct);
        issued++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all requests handed over, then every result checked, then a short tail
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue_top.f
+incdir+sv
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_top.sv
verif/tb_double_ended_queue_top.sv
